// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge outside reset
`define HPC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("hpc assertion failed");

// cond must never be true outside reset
`define HPC_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (!(cond))) \
    else $error("hpc forbidden condition seen");

`endif

// ===== src/hpc_pkg.sv =====
// ----------------------------------------------------------------------------
// hpc_pkg
// Types and constants of the three-axis high-pass complement filter.
// ----------------------------------------------------------------------------
package hpc_pkg;

  localparam int AXES      = 3;
  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 18;
  localparam int HP_W      = 34;
  localparam int RES_W     = 26;
  localparam int FRAC_W    = 16;
  localparam int RES_SHIFT = 8;
  localparam int CFG_IDX_W = 2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [HP_W-1:0]     hp_t;
  typedef logic signed [RES_W-1:0]    res_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_INPUT      = 2'd0,
    CFG_COEF_PREV_INPUT = 2'd1,
    CFG_COEF_FEEDBACK   = 2'd2
  } cfg_idx_e;

  localparam coef_t COEF_INPUT_RST      = 18'sd65066;
  localparam coef_t COEF_PREV_INPUT_RST = -18'sd65066;
  localparam coef_t COEF_FEEDBACK_RST   = 18'sd64596;

  typedef struct packed {
    coef_t a0;
    coef_t a1;
    coef_t b1;
  } coefs_t;

  typedef struct packed {
    logic load_a;
    logic load_b;
    logic load_c;
  } pipe_ctrl_t;

  typedef struct packed {
    logic valid_a;
    logic valid_b;
    logic valid_c;
  } pipe_stat_t;

endpackage

// ===== src/hpc_in_if.sv =====
// ----------------------------------------------------------------------------
// hpc_in_if
// Input channel: one three-axis sample item with valid/ready.
// ----------------------------------------------------------------------------
interface hpc_in_if;
  import hpc_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_x;
  sample_t sample_y;
  sample_t sample_z;

  modport source (output valid, output sample_x, output sample_y, output sample_z,
                  input ready);
  modport sink   (input valid, input sample_x, input sample_y, input sample_z,
                  output ready);
endinterface

// ===== src/hpc_out_if.sv =====
// ----------------------------------------------------------------------------
// hpc_out_if
// Output channel: one three-axis residual item with valid/ready.
// ----------------------------------------------------------------------------
interface hpc_out_if;
  import hpc_pkg::*;

  logic valid;
  logic ready;
  res_t residual_x;
  res_t residual_y;
  res_t residual_z;

  modport source (output valid, output residual_x, output residual_y,
                  output residual_z, input ready);
  modport sink   (input valid, input residual_x, input residual_y,
                  input residual_z, output ready);
endinterface

// ===== src/hpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// hpc_ctrl
// Valid/ready control of the three-stage lane pipeline; stages advance
// independently so bubbles collapse.
// ----------------------------------------------------------------------------
module hpc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                out_ready_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  output hpc_pkg::pipe_ctrl_t ctrl_o,
  output hpc_pkg::pipe_stat_t stat_o
);
  import hpc_pkg::*;

  logic va_q, vb_q, vc_q;
  logic va_d, vb_d, vc_d;
  logic rdy_a, rdy_b, rdy_c;

  assign rdy_c = !vc_q || out_ready_i;
  assign rdy_b = !vb_q || rdy_c;
  assign rdy_a = !va_q || rdy_b;

  assign ctrl_o.load_a = in_valid_i && rdy_a;
  assign ctrl_o.load_b = va_q && rdy_b;
  assign ctrl_o.load_c = vb_q && rdy_c;

  assign va_d = ctrl_o.load_a || (va_q && !rdy_b);
  assign vb_d = ctrl_o.load_b || (vb_q && !rdy_c);
  assign vc_d = ctrl_o.load_c || (vc_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      va_q <= va_d;
      vb_q <= vb_d;
      vc_q <= vc_d;
    end
  end

  assign in_ready_o     = rdy_a;
  assign out_valid_o    = vc_q;
  assign stat_o.valid_a = va_q;
  assign stat_o.valid_b = vb_q;
  assign stat_o.valid_c = vc_q;
endmodule

// ===== src/hpc_lane.sv =====
// ----------------------------------------------------------------------------
// hpc_lane
// One axis: feed-forward products, feedback recurrence with saturation,
// then rounded and saturated residual.
// ----------------------------------------------------------------------------
module hpc_lane (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hpc_pkg::pipe_ctrl_t ctrl_i,
  input  hpc_pkg::coefs_t     coefs_i,
  input  hpc_pkg::sample_t    sample_i,
  output hpc_pkg::res_t       residual_o
);
  import hpc_pkg::*;

  localparam int PROD_W = COEF_W + SAMPLE_W;
  localparam int P_W    = PROD_W + 1;
  localparam int FBP_W  = COEF_W + HP_W;
  localparam int FB_W   = FBP_W - FRAC_W;
  localparam int Y_W    = ((P_W > FB_W) ? P_W : FB_W) + 1;
  localparam int R_W    = HP_W + 1;
  localparam int RS_W   = R_W - RES_SHIFT;

  localparam logic signed [FBP_W-1:0] FB_HALF  = FBP_W'(1) << (FRAC_W - 1);
  localparam logic signed [R_W-1:0]   RES_HALF = R_W'(1) << (RES_SHIFT - 1);

  logic signed [PROD_W-1:0] m0, m1;
  logic signed [P_W-1:0]    p_d, pa_q;
  logic signed [FBP_W-1:0]  mfb, fb_rnd;
  logic signed [FB_W-1:0]   fb;
  logic signed [Y_W-1:0]    ysum;
  logic signed [R_W-1:0]    rsum;
  logic signed [RS_W-1:0]   rsh;
  sample_t                  xprev_q, xa_q, xb_q;
  hp_t                      yprev_q, y_d;
  res_t                     res_d, res_q;

  // stage A: terms that do not depend on the recurrence
  assign m0  = PROD_W'(coefs_i.a0) * PROD_W'(sample_i);
  assign m1  = PROD_W'(coefs_i.a1) * PROD_W'(xprev_q);
  assign p_d = P_W'(m0) + P_W'(m1);

  // stage B: feedback term, round half up, saturate
  assign mfb    = FBP_W'(coefs_i.b1) * FBP_W'(yprev_q);
  assign fb_rnd = mfb + FB_HALF;
  assign fb     = fb_rnd[FBP_W-1:FRAC_W];
  assign ysum   = Y_W'(pa_q) + Y_W'(fb);

  always_comb begin
    if ((&ysum[Y_W-1:HP_W-1]) || !(|ysum[Y_W-1:HP_W-1])) begin
      y_d = ysum[HP_W-1:0];
    end else if (ysum[Y_W-1]) begin
      y_d = {1'b1, {(HP_W-1){1'b0}}};
    end else begin
      y_d = {1'b0, {(HP_W-1){1'b1}}};
    end
  end

  // stage C: residual x - y, round half up, saturate
  assign rsum = R_W'(signed'({xb_q, {FRAC_W{1'b0}}})) - R_W'(yprev_q) + RES_HALF;
  assign rsh  = rsum[R_W-1:RES_SHIFT];

  always_comb begin
    if ((&rsh[RS_W-1:RES_W-1]) || !(|rsh[RS_W-1:RES_W-1])) begin
      res_d = rsh[RES_W-1:0];
    end else if (rsh[RS_W-1]) begin
      res_d = {1'b1, {(RES_W-1){1'b0}}};
    end else begin
      res_d = {1'b0, {(RES_W-1){1'b1}}};
    end
  end

  // filter state; yprev_q doubles as the stage B output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xprev_q <= '0;
      yprev_q <= '0;
    end else begin
      if (ctrl_i.load_a) begin
        xprev_q <= sample_i;
      end
      if (ctrl_i.load_b) begin
        yprev_q <= y_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_a) begin
      pa_q <= p_d;
      xa_q <= sample_i;
    end
    if (ctrl_i.load_b) begin
      xb_q <= xa_q;
    end
    if (ctrl_i.load_c) begin
      res_q <= res_d;
    end
  end

  assign residual_o = res_q;
endmodule

// ===== src/three_axis_highpass_complement.sv =====
// ----------------------------------------------------------------------------
// three_axis_highpass_complement
// Per-axis first-order high-pass filter returning sample minus filter output.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one item of three signed 16-bit samples; out_o returns one
//   item of three signed 26-bit residuals (8 fraction bits) per input item,
//   in order. Both are valid/ready channels.
//   Coefficients a0, a1, b1 (signed Q2.16) are written through cfg_we_i,
//   cfg_idx_i and cfg_wdata_i while the block is idle; index 3 is ignored.
//   Pipeline: three register stages A, B and C, the first loaded at the input
//   accept edge; out_o.valid is the valid flag of stage C.
//   Throughput: one item per cycle unless out_o stalls. The per-axis recurrence
//   closes through the 18x34 feedback multiply, add and saturation of stage B.
//   All three axes run in parallel lanes sharing one control pipeline.
//   Reset clears the filter state to zero, loads the default coefficients
//   and empties the pipeline.
//   When the receiver stalls, results stay in the output register and the
//   two earlier stages keep filling; in_i.ready drops only once all three
//   stages hold an item.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module three_axis_highpass_complement (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hpc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  hpc_pkg::coef_t                cfg_wdata_i,
  hpc_in_if.sink                        in_i,
  hpc_out_if.source                     out_o
);
  import hpc_pkg::*;

  coefs_t     coefs_q;
  pipe_ctrl_t ctrl;
  pipe_stat_t stat;
  sample_t    samples [AXES];
  res_t       res     [AXES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coefs_q.a0 <= COEF_INPUT_RST;
      coefs_q.a1 <= COEF_PREV_INPUT_RST;
      coefs_q.b1 <= COEF_FEEDBACK_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_COEF_INPUT:      coefs_q.a0 <= cfg_wdata_i;
        CFG_COEF_PREV_INPUT: coefs_q.a1 <= cfg_wdata_i;
        CFG_COEF_FEEDBACK:   coefs_q.b1 <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  hpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .ctrl_o      (ctrl),
    .stat_o      (stat)
  );

  assign samples[0] = in_i.sample_x;
  assign samples[1] = in_i.sample_y;
  assign samples[2] = in_i.sample_z;

  for (genvar g = 0; g < AXES; g++) begin : g_lane
    hpc_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .coefs_i    (coefs_q),
      .sample_i   (samples[g]),
      .residual_o (res[g])
    );
  end

  assign out_o.residual_x = res[0];
  assign out_o.residual_y = res[1];
  assign out_o.residual_z = res[2];

  `HPC_ASSERT(a_stall_only_full, clk_i, rst_ni, !in_i.ready |-> (stat.valid_a && stat.valid_b && stat.valid_c))
  `HPC_ASSERT(a_load_b_has_item, clk_i, rst_ni, ctrl.load_b |-> stat.valid_a)
  `HPC_ASSERT_NEVER(a_load_c_empty, clk_i, rst_ni, ctrl.load_c && !stat.valid_b)
  `HPC_ASSERT(a_load_c_shows, clk_i, rst_ni, ctrl.load_c |=> out_o.valid)
endmodule
